### rtl/wms_pkg.sv
// shared types, widths, register codes and constants of the weighted motion smoother
package wms_pkg;

  // item fields
  localparam int DELTA_W    = 16;
  localparam int POS_W      = 16;
  localparam int IN_DATA_W  = 4 * DELTA_W;
  localparam int OUT_DATA_W = 2 * POS_W;

  // configuration registers
  localparam int WLEN_W     = 7;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 1'b1;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd1;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd58982;

  // history depth default and attenuation range in quarter steps
  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam int DECAY_TABLE_DEPTH  = 256;

  // datapath widths
  localparam int PSUM_W     = 24;  // running plain sum over at most 127 motions
  localparam int WSUM_W     = 32;  // weighted sum, two's complement
  localparam int SUM_MAG_W  = 31;
  localparam int FRAC_W     = 8;
  localparam int DEN_W      = 14;  // n(n+1) for n up to 127
  localparam int DIVIDEND_W = SUM_MAG_W + FRAC_W + 1;
  localparam int AVG_W      = 24;  // magnitude of a Q8 average
  localparam int FACT_W     = 17;  // Q0.16 factor, 1.0 included
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 24;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int FG_W       = 32;  // factor times gain
  localparam int PLO_W      = 40;
  localparam int PROD_W     = 57;
  localparam int STEP_W     = 17;
  localparam int K_W        = 18;
  localparam int DEC_ITER_W = $clog2(DECAY_TABLE_DEPTH);

  // 0.7 in Q0.16 and the rounding constant of one decay step
  localparam logic [GAIN_W-1:0] DECAY_STEP = 16'd45875;
  localparam logic [32:0]       ROUND_Q16  = 33'd32768;

  // one history entry
  typedef struct packed {
    logic [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0] dx;
  } motion_t;

  // 0.7 to the power 0, 0.25, 0.5, 0.75 in Q0.16
  function automatic logic [FACT_W-1:0] quarter_root(input logic [1:0] sel);
    logic [FACT_W-1:0] r;
    unique case (sel)
      2'd0: r = 17'd65536;
      2'd1: r = 17'd59945;
      2'd2: r = 17'd54831;
      2'd3: r = 17'd50154;
    endcase
    return r;
  endfunction

endpackage

### rtl/wms_ram.sv
// generic single write port ram with registered read
module wms_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wms_mul.sv
// shared unsigned multiplier with registered product
module wms_mul import wms_pkg::*; (
  input  logic               clk,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  // product is held until the next start
  always_ff @(posedge clk) begin
    if (start) begin
      p <= MUL_P_W'(a) * MUL_P_W'(b);
    end
  end

endmodule

### rtl/wms_div.sv
// restoring divider, one quotient bit per cycle
module wms_div import wms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  output logic                  done,
  output logic [AVG_W-1:0]      quotient
);
  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [DEN_W-1:0]      rem;
  logic [DIVIDEND_W-1:0] dq;
  logic [DEN_W:0]        trial;
  logic [DEN_W:0]        diff;
  logic                  fits;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem, dq[DIVIDEND_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
    end else if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dq  <= {dq[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = dq[AVG_W-1:0];

endmodule

### rtl/weighted_motion_smoother_unit.sv
// Weighted motion smoother: one input transaction carries a relative motion and the current
// cursor position and yields one transaction with the new saturated position. The block works
// on one item at a time and is not ready until its result has been handed to the output
// register. Per item it reads n averaged motions from the history ram, one read per cycle, runs
// the two 40-step divisions of the shared divider, and runs up to about 35 decay steps of 0.7
// on the shared multiplier (they stop early once the factor no longer changes, and none run
// for large motion or for small motion under one whole decay step).
// The output register lets a new item enter while the previous result still waits.
module weighted_motion_smoother_unit import wms_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // delta_x [15:0], delta_y [31:16], cursor_x [47:32], cursor_y [63:48]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // next_x [15:0], next_y [31:16]
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_MAX - 1);
  localparam logic [8:0]       N_CAP    = 9'(WINDOW_MAX);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_WALK    = 5'd1;
  localparam logic [4:0] S_DX_GO   = 5'd2;
  localparam logic [4:0] S_DX_RUN  = 5'd3;
  localparam logic [4:0] S_DY_GO   = 5'd4;
  localparam logic [4:0] S_DY_RUN  = 5'd5;
  localparam logic [4:0] S_KSEL    = 5'd6;
  localparam logic [4:0] S_DEC_MUL = 5'd7;
  localparam logic [4:0] S_DEC_UPD = 5'd8;
  localparam logic [4:0] S_FG_MUL  = 5'd9;
  localparam logic [4:0] S_FG_LAT  = 5'd10;
  localparam logic [4:0] S_X_LO    = 5'd11;
  localparam logic [4:0] S_X_HI    = 5'd12;
  localparam logic [4:0] S_X_FIN   = 5'd13;
  localparam logic [4:0] S_Y_LO    = 5'd14;
  localparam logic [4:0] S_Y_HI    = 5'd15;
  localparam logic [4:0] S_Y_FIN   = 5'd16;
  localparam logic [4:0] S_OUT     = 5'd17;

  logic [4:0]        state;
  logic [WLEN_W-1:0] window_length;
  logic [GAIN_W-1:0] gain;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rd_ptr;
  logic [WLEN_W-1:0] fill;
  logic [WLEN_W-1:0] cnt;
  logic              rd_valid;

  logic [WLEN_W-1:0] wl_eff;
  logic [WLEN_W-1:0] n_eff;
  logic [WLEN_W:0]   fill_inc;
  logic [WLEN_W-1:0] fill_next;
  logic              accept;
  logic              out_free;

  motion_t           ram_rdata;
  logic [PSUM_W-1:0] psum_x;
  logic [PSUM_W-1:0] psum_y;
  logic [PSUM_W-1:0] psum_x_next;
  logic [PSUM_W-1:0] psum_y_next;
  logic [WSUM_W-1:0] wsum_x;
  logic [WSUM_W-1:0] wsum_y;
  logic [DEN_W-1:0]  den;

  logic [POS_W-1:0]  cur_x;
  logic [POS_W-1:0]  cur_y;
  logic [POS_W-1:0]  nx;
  logic [POS_W-1:0]  ny;

  logic                  div_start;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [AVG_W-1:0]      div_q;
  logic [WSUM_W-1:0]     div_sum;
  logic [WSUM_W-1:0]     div_abs;

  logic [AVG_W-1:0]      mag_x;
  logic [AVG_W-1:0]      mag_y;
  logic                  neg_x;
  logic                  neg_y;

  logic [AVG_W:0]          abs_sum;
  logic [K_W-1:0]          k;
  logic [FACT_W-1:0]       d;
  logic [DEC_ITER_W-1:0]   iter;
  logic [32:0]             dec_rnd;
  logic [FACT_W-1:0]       d_new;
  logic [FG_W-1:0]         fg;

  logic                mul_start;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;

  logic [PLO_W-1:0]    plo;
  logic [PROD_W-1:0]   prod_rnd;
  logic [STEP_W-1:0]   step;
  logic [POS_W-1:0]    fin_cur;
  logic                fin_neg;
  logic [POS_W+1:0]    pos;
  logic [POS_W-1:0]    pos_sat;

  assign cfg_ready = !rst;
  assign s_tready  = !rst && (state == S_IDLE);
  assign accept    = s_tvalid & s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // effective window and new fill count
  always_comb begin
    wl_eff    = (window_length == '0) ? WLEN_W'(1) : window_length;
    n_eff     = ({2'b0, wl_eff} > N_CAP) ? N_CAP[WLEN_W-1:0] : wl_eff;
    fill_inc  = {1'b0, fill} + 1'b1;
    fill_next = (fill_inc > {1'b0, n_eff}) ? n_eff : fill_inc[WLEN_W-1:0];
  end

  // motion history
  wms_ram #(
    .WIDTH ($bits(motion_t)),
    .DEPTH (WINDOW_MAX)
  ) u_hist (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (s_tdata[2*DELTA_W-1:0]),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  // prefix sums, newest first, so the newest motion is counted n times
  always_comb begin
    psum_x_next = psum_x + {{(PSUM_W-DELTA_W){ram_rdata.dx[DELTA_W-1]}}, ram_rdata.dx};
    psum_y_next = psum_y + {{(PSUM_W-DELTA_W){ram_rdata.dy[DELTA_W-1]}}, ram_rdata.dy};
  end

  // divider operands: rounded Q8 quotient of the weighted sum by n(n+1)/2
  always_comb begin
    div_start    = (state == S_DX_GO) || (state == S_DY_GO);
    div_sum      = (state == S_DX_GO) ? wsum_x : wsum_y;
    div_abs      = div_sum[WSUM_W-1] ? (~div_sum + 1'b1) : div_sum;
    div_dividend = {div_abs[SUM_MAG_W-1:0], {(FRAC_W+1){1'b0}}}
                   + DIVIDEND_W'(den >> 1);
  end

  wms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (den),
    .done     (div_done),
    .quotient (div_q)
  );

  // attenuation index in quarter steps and one rounded decay step
  always_comb begin
    abs_sum = {1'b0, mag_x} + {1'b0, mag_y};
    k       = abs_sum[AVG_W:7];
    dec_rnd = mul_p[32:0] + ROUND_Q16;
    d_new   = dec_rnd[32:16];
  end

  // shared multiplier operand select
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_IDLE: begin
        mul_start = accept;
        mul_a     = MUL_A_W'(fill_next);
        mul_b     = MUL_B_W'(fill_next) + 1'b1;
      end
      S_DEC_MUL: begin
        mul_start = 1'b1;
        mul_a     = d;
        mul_b     = MUL_B_W'(DECAY_STEP);
      end
      S_FG_MUL: begin
        mul_start = 1'b1;
        mul_a     = d;
        mul_b     = MUL_B_W'(gain);
      end
      S_X_LO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(fg[15:0]);
        mul_b     = mag_x;
      end
      S_X_HI: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(fg[FG_W-1:16]);
        mul_b     = mag_x;
      end
      S_Y_LO: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(fg[15:0]);
        mul_b     = mag_y;
      end
      S_Y_HI: begin
        mul_start = 1'b1;
        mul_a     = MUL_A_W'(fg[FG_W-1:16]);
        mul_b     = mag_y;
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  wms_mul u_mul (
    .clk   (clk),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p)
  );

  // Q40 step rounded half away from zero, added to the cursor and saturated
  always_comb begin
    fin_cur  = (state == S_X_FIN) ? cur_x : cur_y;
    fin_neg  = (state == S_X_FIN) ? neg_x : neg_y;
    prod_rnd = {1'b0, mul_p[PLO_W-1:0], 16'b0} + PROD_W'(plo) + (PROD_W'(1) << 39);
    step     = prod_rnd[PROD_W-1:40];
    pos      = {{2{fin_cur[POS_W-1]}}, fin_cur}
               + (fin_neg ? (~{1'b0, step} + 1'b1) : {1'b0, step});
    if (!pos[POS_W+1] && (pos[POS_W:POS_W-1] != 2'b00)) begin
      pos_sat = {1'b0, {(POS_W-1){1'b1}}};
    end else if (pos[POS_W+1] && (pos[POS_W:POS_W-1] != 2'b11)) begin
      pos_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      pos_sat = pos[POS_W-1:0];
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WLEN_RESET;
      gain          <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_LENGTH: window_length <= cfg_data[WLEN_W-1:0];
        REG_GAIN:          gain          <= cfg_data[GAIN_W-1:0];
      endcase
    end
  end

  // output valid, set when a result is loaded and cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wp       <= '0;
      fill     <= '0;
      cnt      <= '0;
      rd_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wp       <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
            fill     <= fill_next;
            cnt      <= fill_next;
            rd_valid <= 1'b0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          rd_valid <= (cnt != '0);
          if (cnt != '0) begin
            cnt <= cnt - 1'b1;
          end else if (!rd_valid) begin
            state <= S_DX_GO;
          end
        end
        S_DX_GO:  state <= S_DX_RUN;
        S_DX_RUN: if (div_done) state <= S_DY_GO;
        S_DY_GO:  state <= S_DY_RUN;
        S_DY_RUN: if (div_done) state <= S_KSEL;
        S_KSEL: begin
          if ((k >= K_W'(DECAY_TABLE_DEPTH)) || (k[DEC_ITER_W+1:2] == '0)) begin
            state <= S_FG_MUL;
          end else begin
            state <= S_DEC_MUL;
          end
        end
        S_DEC_MUL: state <= S_DEC_UPD;
        S_DEC_UPD: begin
          if ((d_new == d) || (iter == DEC_ITER_W'(1))) begin
            state <= S_FG_MUL;
          end else begin
            state <= S_DEC_MUL;
          end
        end
        S_FG_MUL: state <= S_FG_LAT;
        S_FG_LAT: state <= S_X_LO;
        S_X_LO:   state <= S_X_HI;
        S_X_HI:   state <= S_X_FIN;
        S_X_FIN:  state <= S_Y_LO;
        S_Y_LO:   state <= S_Y_HI;
        S_Y_HI:   state <= S_Y_FIN;
        S_Y_FIN:  state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_ptr <= wp;
          psum_x <= '0;
          psum_y <= '0;
          wsum_x <= '0;
          wsum_y <= '0;
          cur_x  <= s_tdata[3*DELTA_W-1:2*DELTA_W];
          cur_y  <= s_tdata[4*DELTA_W-1:3*DELTA_W];
        end
      end
      S_WALK: begin
        if (cnt != '0) begin
          rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - 1'b1;
        end
        if (rd_valid) begin
          psum_x <= psum_x_next;
          psum_y <= psum_y_next;
          wsum_x <= wsum_x + {{(WSUM_W-PSUM_W){psum_x_next[PSUM_W-1]}}, psum_x_next};
          wsum_y <= wsum_y + {{(WSUM_W-PSUM_W){psum_y_next[PSUM_W-1]}}, psum_y_next};
        end
        den <= mul_p[DEN_W-1:0];
      end
      S_DX_GO:  neg_x <= wsum_x[WSUM_W-1];
      S_DX_RUN: if (div_done) mag_x <= div_q;
      S_DY_GO:  neg_y <= wsum_y[WSUM_W-1];
      S_DY_RUN: if (div_done) mag_y <= div_q;
      S_KSEL: begin
        if (k >= K_W'(DECAY_TABLE_DEPTH)) begin
          d <= '0;
        end else begin
          d <= quarter_root(k[1:0]);
        end
        iter <= k[DEC_ITER_W+1:2];
      end
      S_DEC_UPD: begin
        d    <= d_new;
        iter <= iter - 1'b1;
      end
      S_FG_LAT: fg  <= mul_p[FG_W-1:0];
      S_X_HI:   plo <= mul_p[PLO_W-1:0];
      S_X_FIN:  nx  <= pos_sat;
      S_Y_HI:   plo <= mul_p[PLO_W-1:0];
      S_Y_FIN:  ny  <= pos_sat;
      S_OUT:    if (out_free) m_tdata <= {ny, nx};
      default: begin
      end
    endcase
  end

endmodule
